// File: hdl/prt_pkg.sv
`default_nettype none
package prt_pkg;

	localparam int unsigned FieldNumberWidth = 61;
	localparam int unsigned WireKindWidth = 3;
	localparam int unsigned ValueWidth = 64;
	localparam int unsigned StatusWidth = 2;

	localparam logic [StatusWidth-1:0] ST_OK = 2'd0;
	localparam logic [StatusWidth-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [StatusWidth-1:0] ST_BAD_WIRE = 2'd2;
	localparam logic [StatusWidth-1:0] ST_TRUNCATED = 2'd3;

	localparam logic [WireKindWidth-1:0] WK_VARINT = 3'd0;
	localparam logic [WireKindWidth-1:0] WK_FIXED64 = 3'd1;
	localparam logic [WireKindWidth-1:0] WK_LENGTH = 3'd2;
	localparam logic [WireKindWidth-1:0] WK_FIXED32 = 3'd5;

	typedef struct packed {
		logic                       valid;
		logic [FieldNumberWidth-1:0] field_id;
		logic [WireKindWidth-1:0]    wire_kind;
		logic [ValueWidth-1:0]       record_value;
		logic [StatusWidth-1:0]      status;
	} record_t;

endpackage
`default_nettype wire

// File: hdl/prt_in_if.sv
`default_nettype none
interface prt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_message;

	modport source (output valid, output data_byte, output end_of_message, input ready);
	modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface
`default_nettype wire

// File: hdl/prt_out_if.sv
`default_nettype none
interface prt_out_if;
	logic        valid;
	logic        ready;
	logic [60:0] field_id;
	logic [2:0]  wire_kind;
	logic [63:0] record_value;
	logic [1:0]  status;

	modport source (output valid, output field_id, output wire_kind,
		output record_value, output status, input ready);
	modport sink (input valid, input field_id, input wire_kind,
		input record_value, input status, output ready);
endinterface
`default_nettype wire

// File: hdl/prt_step.sv
`default_nettype none
module prt_step
	import prt_pkg::*;
#(
	parameter int unsigned MAX_VARINT_BITS = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	output record_t         rec
);

	localparam logic [2:0] PH_TAG = 3'd0;
	localparam logic [2:0] PH_VARINT = 3'd1;
	localparam logic [2:0] PH_FIXED = 3'd2;
	localparam logic [2:0] PH_LENGTH = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [7:0] MaxBits = 8'(MAX_VARINT_BITS);

	logic [2:0]                  phase_q, phase_n;
	logic [ValueWidth-1:0]       acc_q, acc_n;
	logic [6:0]                  bp_q, bp_n;
	logic [FieldNumberWidth-1:0] held_fn_q, held_fn_n;
	logic [WireKindWidth-1:0]    held_wk_q, held_wk_n;
	logic [ValueWidth-1:0]       rem_q, rem_n;
	logic                        disc_q, disc_n;

	logic [6:0]            payload;
	logic [7:0]            room;
	logic                  vi_ovf;
	logic                  vi_done;
	logic [ValueWidth-1:0] vi_acc;
	logic [6:0]            vi_bp;
	logic [ValueWidth-1:0] fix_acc;
	logic [ValueWidth-1:0] rem_dec;

	// one base-128 digit, or one fixed-field byte, folded into the accumulator; remaining count decremented
	always_comb begin
		payload = data_byte[6:0];
		room = MaxBits - {1'b0, bp_q};
		vi_ovf = 1'b0;
		if ({1'b0, bp_q} >= MaxBits) begin
			vi_ovf = 1'b1;
		end else if ({1'b0, bp_q} + 8'd7 > MaxBits) begin
			vi_ovf = (payload >> room[2:0]) != 7'd0;
		end
		vi_done = !data_byte[7];
		vi_acc = acc_q | ({57'd0, payload} << bp_q[5:0]);
		vi_bp = bp_q + 7'd7;
		fix_acc = bp_q[6] ? acc_q : (acc_q | ({56'd0, data_byte} << bp_q[5:0]));
		rem_dec = (rem_q != '0) ? rem_q - 64'd1 : rem_q;
	end

	always_comb begin
		phase_n = phase_q;
		acc_n = acc_q;
		bp_n = bp_q;
		held_fn_n = held_fn_q;
		held_wk_n = held_wk_q;
		rem_n = rem_q;
		disc_n = disc_q;
		rec = '0;

		if (!disc_q) begin
			unique case (phase_q)
				PH_VARINT: begin
					if (vi_ovf) begin
						disc_n = 1'b1;
						rec = '{1'b1, held_fn_q, held_wk_q, '0, ST_OVERFLOW};
					end else begin
						acc_n = vi_acc;
						bp_n = vi_bp;
						if (vi_done) begin
							rec = '{1'b1, held_fn_q, held_wk_q, vi_acc, ST_OK};
							phase_n = PH_TAG;
							acc_n = '0;
							bp_n = '0;
							rem_n = '0;
						end
					end
				end
				PH_FIXED: begin
					acc_n = fix_acc;
					bp_n = bp_q + 7'd8;
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						rec = '{1'b1, held_fn_q, held_wk_q, fix_acc, ST_OK};
						phase_n = PH_TAG;
						acc_n = '0;
						bp_n = '0;
					end
				end
				PH_LENGTH: begin
					if (vi_ovf) begin
						disc_n = 1'b1;
						rec = '{1'b1, held_fn_q, held_wk_q, '0, ST_OVERFLOW};
					end else begin
						acc_n = vi_acc;
						bp_n = vi_bp;
						if (vi_done) begin
							if (vi_acc == '0) begin
								rec = '{1'b1, held_fn_q, held_wk_q, '0, ST_OK};
								phase_n = PH_TAG;
								acc_n = '0;
								bp_n = '0;
								rem_n = '0;
							end else begin
								rem_n = vi_acc;
								phase_n = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						rec = '{1'b1, held_fn_q, held_wk_q, acc_q, ST_OK};
						phase_n = PH_TAG;
						acc_n = '0;
						bp_n = '0;
					end
				end
				default: begin
					phase_n = PH_TAG;
					if (vi_ovf) begin
						disc_n = 1'b1;
						rec = '{1'b1, '0, '0, '0, ST_OVERFLOW};
					end else begin
						acc_n = vi_acc;
						bp_n = vi_bp;
						if (vi_done) begin
							held_fn_n = vi_acc[ValueWidth-1:3];
							held_wk_n = vi_acc[2:0];
							acc_n = '0;
							bp_n = '0;
							unique case (vi_acc[2:0])
								WK_VARINT: phase_n = PH_VARINT;
								WK_FIXED64: begin
									phase_n = PH_FIXED;
									rem_n = 64'd8;
								end
								WK_LENGTH: phase_n = PH_LENGTH;
								WK_FIXED32: begin
									phase_n = PH_FIXED;
									rem_n = 64'd4;
								end
								default: begin
									disc_n = 1'b1;
									rec = '{1'b1, vi_acc[ValueWidth-1:3], vi_acc[2:0], '0,
										ST_BAD_WIRE};
								end
							endcase
						end
					end
				end
			endcase

			// close an open record at the end of the message
			if (end_of_message && !rec.valid) begin
				if (phase_n != PH_TAG) begin
					rec = '{1'b1, held_fn_n, held_wk_n, '0, ST_TRUNCATED};
				end else if (bp_n != '0) begin
					rec = '{1'b1, '0, '0, '0, ST_TRUNCATED};
				end
			end
		end

		if (end_of_message) begin
			phase_n = PH_TAG;
			acc_n = '0;
			bp_n = '0;
			held_fn_n = '0;
			held_wk_n = '0;
			rem_n = '0;
			disc_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q <= '0;
			bp_q <= '0;
			held_fn_q <= '0;
			held_wk_q <= '0;
			rem_q <= '0;
			disc_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q <= acc_n;
			bp_q <= bp_n;
			held_fn_q <= held_fn_n;
			held_wk_q <= held_wk_n;
			rem_q <= rem_n;
			disc_q <= disc_n;
		end
	end

endmodule
`default_nettype wire

// File: hdl/protobuf_record_tokenizer.sv
`default_nettype none
// Record path: a record's last byte is registered in the byte register, and the record it
// closes is then registered in the record register, from which it is offered.
// Throughput: one byte per cycle; the byte register and the record register both
// advance whenever the record register is empty or being taken.
// Reset (arst_n low): clears all decode state and drops any held byte and record.
// Bytes inside a discarded message and bytes that close no record give no result.
module protobuf_record_tokenizer
	import prt_pkg::*;
#(
	parameter int unsigned MAX_VARINT_BITS = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	prt_in_if.sink   byte_stream,
	prt_out_if.source records
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eom_s1;
	logic       advance;
	record_t    rec;
	record_t    out_q;

	assign advance = !out_q.valid || records.ready;
	assign byte_stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			data_s1 <= byte_stream.data_byte;
			eom_s1 <= byte_stream.end_of_message;
		end
	end

	prt_step #(
		.MAX_VARINT_BITS(MAX_VARINT_BITS)
	) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (valid_s1 && advance),
		.data_byte     (data_s1),
		.end_of_message(eom_s1),
		.rec           (rec)
	);

	// hold the record until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= valid_s1 ? rec : '0;
		end
	end

	assign records.valid = out_q.valid;
	assign records.field_id = out_q.field_id;
	assign records.wire_kind = out_q.wire_kind;
	assign records.record_value = out_q.record_value;
	assign records.status = out_q.status;

endmodule
`default_nettype wire
